// ===== rtl/tphb_pkg.sv =====
// tphb_pkg: shared types and constants of the TCP probe header builder.
// No dependencies; used by tcp_probe_header_builder and tphb_checker.
package tphb_pkg;

   // request word
   typedef struct packed {
      logic [31:0] source_address;
      logic [15:0] source_port;
      logic [31:0] dest_address;
      logic [15:0] dest_port;
      logic [1:0]  probe_kind;
   } probe_req_type;

   // response word
   typedef struct packed {
      logic [3:0]  word_index;
      logic [31:0] header_word;
      logic        last_word;
   } header_rsp_type;

   // per-request fields carried down the pipe
   typedef struct packed {
      logic [31:0] saddr;
      logic [31:0] daddr;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [15:0] ident;
      logic [7:0]  ttl;
      logic [7:0]  flags;
      logic [15:0] window;
   } pipe_item_type;

   // configuration register indexes
   localparam logic [1:0] CsrIpIdent    = 2'd0;
   localparam logic [1:0] CsrTimeToLive = 2'd1;
   localparam logic [1:0] CsrWindowSize = 2'd2;

   localparam logic [15:0] IdentReset  = 16'd54321;
   localparam logic [7:0]  TtlReset    = 8'd64;
   localparam logic [15:0] WindowReset = 16'd512;

   // probe kinds
   localparam logic [1:0] KindSyn = 2'd1;
   localparam logic [1:0] KindFin = 2'd2;

   localparam logic [7:0] FlagSyn = 8'h02;
   localparam logic [7:0] FlagFin = 8'h01;

   // fixed header content
   localparam logic [31:0] IpWord0   = 32'h4500_0028; // ver 4, IHL 5, len 40
   localparam logic [7:0]  ProtoTcp  = 8'd6;
   localparam logic [15:0] TcpLength = 16'd20;
   localparam logic [7:0]  TcpOffset = 8'h50;       // data offset 5

   localparam int unsigned   HdrWords = 10;
   localparam logic [3:0]    LastIdx  = 4'(HdrWords - 1);

endpackage

// ===== rtl/tcp_probe_header_builder.sv =====
// tcp_probe_header_builder: builds a 40-byte IPv4 + TCP probe header, ten words.
// Depends on tphb_pkg.
//
//  channel | direction | handshake     | payload
//  req_    | in        | valid / stall | tphb_pkg::probe_req_type
//  rsp_    | out       | valid / stall | tphb_pkg::header_rsp_type
//  csr_    | in        | valid / ready | index (2b), wdata (16b)
//
// Cycles: each request yields ten response words, one per cycle when rsp_stall
// is low, so the output port sets the sustained request rate.
// Structure: 4 pipe stages (capture, raw sums, first fold, final fold) plus the
// serializer; the stages accept new requests while a header is still being sent.
// Reset: synchronous, clears all valids and loads the register defaults.
// Stalls: each stage holds while the one after is full and not moving; the
// serializer loads the next header in the cycle its last word is taken.
module tcp_probe_header_builder (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  tphb_pkg::probe_req_type  req_data,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output tphb_pkg::header_rsp_type rsp_data,
   // register write port
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [15:0]              csr_wdata
);

   // ---------------- config registers ----------------
   logic [15:0] ident_ff, ident_in;
   logic [7:0]  ttl_ff, ttl_in;
   logic [15:0] window_ff, window_in;

   assign csr_ready = 1'b1;

   always_comb begin
      ident_in  = ident_ff;
      ttl_in    = ttl_ff;
      window_in = window_ff;
      if (csr_valid) begin
         unique case (csr_index)
            tphb_pkg::CsrIpIdent:    ident_in  = csr_wdata;
            tphb_pkg::CsrTimeToLive: ttl_in    = csr_wdata[7:0];
            tphb_pkg::CsrWindowSize: window_in = csr_wdata;
            default: ;  // unused index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ident_ff  <= tphb_pkg::IdentReset;
         ttl_ff    <= tphb_pkg::TtlReset;
         window_ff <= tphb_pkg::WindowReset;
      end else begin
         ident_ff  <= ident_in;
         ttl_ff    <= ttl_in;
         window_ff <= window_in;
      end
   end

   // ---------------- pipe control ----------------
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, out_v_ff;
   logic s1_take, s2_take, s3_take, s4_take;
   logic out_fire, out_done, out_load;
   logic [3:0] out_idx_ff, out_idx_in;

   assign out_fire = out_v_ff && !rsp_stall;
   assign out_done = out_fire && (out_idx_ff == tphb_pkg::LastIdx);
   assign out_load = !out_v_ff || out_done;   // serializer free this cycle

   // a stage takes a new word when empty or when its content moves on
   assign s4_take = !s4_v_ff || out_load;
   assign s3_take = !s3_v_ff || s4_take;
   assign s2_take = !s2_v_ff || s3_take;
   assign s1_take = !s1_v_ff || s2_take;

   assign req_stall = !s1_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         if (s1_take) s1_v_ff <= req_valid;
         if (s2_take) s2_v_ff <= s1_v_ff;
         if (s3_take) s3_v_ff <= s2_v_ff;
         if (s4_take) s4_v_ff <= s3_v_ff;
      end
   end

   // ---------------- stage 1: capture + flag decode ----------------
   tphb_pkg::pipe_item_type s1_item_ff, s1_item_in;

   always_comb begin
      s1_item_in.saddr  = req_data.source_address;
      s1_item_in.daddr  = req_data.dest_address;
      s1_item_in.sport  = req_data.source_port;
      s1_item_in.dport  = req_data.dest_port;
      s1_item_in.ident  = ident_ff;
      s1_item_in.ttl    = ttl_ff;
      s1_item_in.window = window_ff;
      unique case (req_data.probe_kind)
         tphb_pkg::KindSyn: s1_item_in.flags = tphb_pkg::FlagSyn;
         tphb_pkg::KindFin: s1_item_in.flags = tphb_pkg::FlagFin;
         default:           s1_item_in.flags = 8'h00;  // none, and the unused code
      endcase
   end

   always_ff @(posedge clock) begin
      if (s1_take) s1_item_ff <= s1_item_in;
   end

   // ---------------- stage 2: raw 16-bit sums ----------------
   // Up to ten 16-bit terms each, so 20 bits never overflow.
   tphb_pkg::pipe_item_type s2_item_ff;
   logic [19:0] s2_ipsum_ff, s2_ipsum_in;
   logic [19:0] s2_tcpsum_ff, s2_tcpsum_in;
   logic [19:0] addr_sum;

   always_comb begin
      addr_sum = 20'(s1_item_ff.saddr[31:16]) + 20'(s1_item_ff.saddr[15:0])
               + 20'(s1_item_ff.daddr[31:16]) + 20'(s1_item_ff.daddr[15:0]);
      // IPv4 header, checksum field zero
      s2_ipsum_in = addr_sum
                  + 20'(tphb_pkg::IpWord0[31:16]) + 20'(tphb_pkg::IpWord0[15:0])
                  + 20'(s1_item_ff.ident)
                  + 20'({s1_item_ff.ttl, tphb_pkg::ProtoTcp});
      // pseudo-header + TCP header, checksum field zero
      s2_tcpsum_in = addr_sum
                   + 20'(tphb_pkg::ProtoTcp) + 20'(tphb_pkg::TcpLength)
                   + 20'(s1_item_ff.sport) + 20'(s1_item_ff.dport)
                   + 20'({tphb_pkg::TcpOffset, s1_item_ff.flags})
                   + 20'(s1_item_ff.window);
   end

   always_ff @(posedge clock) begin
      if (s2_take) begin
         s2_item_ff   <= s1_item_ff;
         s2_ipsum_ff  <= s2_ipsum_in;
         s2_tcpsum_ff <= s2_tcpsum_in;
      end
   end

   // ---------------- stage 3: first end-around fold ----------------
   tphb_pkg::pipe_item_type s3_item_ff;
   logic [16:0] s3_ipfold_ff, s3_ipfold_in;
   logic [16:0] s3_tcpfold_ff, s3_tcpfold_in;

   assign s3_ipfold_in  = 17'(s2_ipsum_ff[19:16]) + 17'(s2_ipsum_ff[15:0]);
   assign s3_tcpfold_in = 17'(s2_tcpsum_ff[19:16]) + 17'(s2_tcpsum_ff[15:0]);

   always_ff @(posedge clock) begin
      if (s3_take) begin
         s3_item_ff    <= s2_item_ff;
         s3_ipfold_ff  <= s3_ipfold_in;
         s3_tcpfold_ff <= s3_tcpfold_in;
      end
   end

   // ---------------- stage 4: second fold + complement ----------------
   tphb_pkg::pipe_item_type s4_item_ff;
   logic [15:0] s4_ipck_ff, s4_ipck_in;
   logic [15:0] s4_tcpck_ff, s4_tcpck_in;

   assign s4_ipck_in  = ~(s3_ipfold_ff[15:0] + 16'(s3_ipfold_ff[16]));
   assign s4_tcpck_in = ~(s3_tcpfold_ff[15:0] + 16'(s3_tcpfold_ff[16]));

   always_ff @(posedge clock) begin
      if (s4_take) begin
         s4_item_ff  <= s3_item_ff;
         s4_ipck_ff  <= s4_ipck_in;
         s4_tcpck_ff <= s4_tcpck_in;
      end
   end

   // ---------------- serializer / output register ----------------
   tphb_pkg::pipe_item_type hold_item_ff;
   logic [15:0] hold_ipck_ff, hold_tcpck_ff;
   logic [31:0] out_word_ff, out_word_in;
   logic        out_v_in;

   function automatic logic [31:0] header_word_at(
      input logic [3:0]              idx,
      input tphb_pkg::pipe_item_type it,
      input logic [15:0]             ipck,
      input logic [15:0]             tcpck
   );
      logic [31:0] w;
      unique case (idx)
         4'd0:    w = tphb_pkg::IpWord0;
         4'd1:    w = {it.ident, 16'h0000};
         4'd2:    w = {it.ttl, tphb_pkg::ProtoTcp, ipck};
         4'd3:    w = it.saddr;
         4'd4:    w = it.daddr;
         4'd5:    w = {it.sport, it.dport};
         4'd8:    w = {tphb_pkg::TcpOffset, it.flags, it.window};
         4'd9:    w = {tcpck, 16'h0000};
         default: w = 32'h0000_0000;  // seq, ack
      endcase
      return w;
   endfunction

   always_comb begin
      out_v_in    = out_v_ff;
      out_idx_in  = out_idx_ff;
      out_word_in = out_word_ff;
      if (out_load) begin
         out_v_in    = s4_v_ff;
         out_idx_in  = 4'd0;
         out_word_in = header_word_at(4'd0, s4_item_ff, s4_ipck_ff, s4_tcpck_ff);
      end else if (out_fire) begin
         out_idx_in  = out_idx_ff + 4'd1;
         out_word_in = header_word_at(out_idx_ff + 4'd1, hold_item_ff,
                                      hold_ipck_ff, hold_tcpck_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_idx_ff  <= out_idx_in;
      out_word_ff <= out_word_in;
      if (out_load) begin
         hold_item_ff  <= s4_item_ff;
         hold_ipck_ff  <= s4_ipck_ff;
         hold_tcpck_ff <= s4_tcpck_ff;
      end
   end

   assign rsp_valid            = out_v_ff;
   assign rsp_data.word_index  = out_idx_ff;
   assign rsp_data.header_word = out_word_ff;
   assign rsp_data.last_word   = (out_idx_ff == tphb_pkg::LastIdx);

endmodule

// ===== rtl/tphb_checker.sv =====
// tphb_checker: port-level checks on tcp_probe_header_builder, bound to it.
// Depends on tphb_pkg.
module tphb_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input tphb_pkg::header_rsp_type rsp_data
);

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed under stall");

   // words of one header come back to back in order
   a_rsp_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_word |=>
         rsp_valid && rsp_data.word_index == 4'($past(rsp_data.word_index) + 4'd1))
      else $error("rsp word index out of sequence");

   // last flag only on the tenth word
   a_rsp_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_word == (rsp_data.word_index == tphb_pkg::LastIdx)))
      else $error("last_word mismatch");

   // first word is the fixed version/length word
   a_rsp_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.word_index == 4'd0 |->
         rsp_data.header_word == tphb_pkg::IpWord0)
      else $error("bad first header word");

   // nothing out right after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind tcp_probe_header_builder tphb_checker u_tphb_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
